// ===== design/mewf_pkg.sv =====
// ----------------------------------------------------------------------------
// mewf_pkg
// Shared widths, register indexes and state codes of the median/EMA filter.
// ----------------------------------------------------------------------------
package mewf_pkg;

  localparam int unsigned WindowSizeDefault = 5;
  localparam int unsigned WindowSizeMax     = 32;

  localparam int unsigned SampleW  = 24;
  localparam int unsigned GainW    = 32;
  localparam int unsigned AlphaW   = 16;
  localparam int unsigned WeightW  = 48;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CountW   = 5;

  localparam int unsigned Prod1W = SampleW + GainW;  // median * gain
  localparam int unsigned DiffW  = WeightW + 1;      // w - ema
  localparam int unsigned Prod2W = DiffW + AlphaW;   // alpha * diff

  localparam logic [AlphaW-1:0] AlphaReset = 16'd9830;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_RECIPROCAL  = 1'b0,
    REG_SMOOTHING_WEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RANK = 6'b000010,
    ST_MUL1 = 6'b000100,
    ST_SUB  = 6'b001000,
    ST_MUL2 = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

endpackage

// ===== design/mewf_if.sv =====
// ----------------------------------------------------------------------------
// mewf interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface mewf_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [mewf_pkg::SampleW-1:0]      raw_sample;
  modport source (output valid, raw_sample, input ready);
  modport sink   (input valid, raw_sample, output ready);
endinterface

interface mewf_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [mewf_pkg::WeightW-1:0]      filtered_weight;
  logic                                     updated;
  modport source (output valid, filtered_weight, updated, input ready);
  modport sink   (input valid, filtered_weight, updated, output ready);
endinterface

interface mewf_cfg_if;
  logic                                     valid;
  logic                                     ready;
  logic [mewf_pkg::CfgIdxW-1:0]             index;
  logic [mewf_pkg::CfgDataW-1:0]            data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/median_ema_weight_filter.sv =====
// Sequence per calibrated item: rank scan (stops at the median slot or the
// last slot), serial gain multiply, subtract, serial smoothing multiply and
// output; an uncalibrated item goes straight to the output step.
// One item at a time: a new sample is taken only in the idle state, and the
// output step waits while a result is pending. Reset clears window,
// write slot and average at once; items are taken from the first cycle after.
// ----------------------------------------------------------------------------
// median_ema_weight_filter
// Windowed median of load-cell samples, gain scaling and exponential
// smoothing, using a rank sequencer and bit-serial multipliers.
// ----------------------------------------------------------------------------
module median_ema_weight_filter #(
  parameter int unsigned WINDOW_SIZE = mewf_pkg::WindowSizeDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mewf_cfg_if.sink    cfg_i,
  mewf_in_if.sink     in_i,
  mewf_out_if.source  out_o
);

  localparam int unsigned IdxW  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned RankW = $clog2(WINDOW_SIZE + 1);
  localparam logic [RankW-1:0] MedRank = RankW'(WINDOW_SIZE / 2);
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(WINDOW_SIZE - 1);

  localparam int unsigned SW = mewf_pkg::SampleW;
  localparam int unsigned P1 = mewf_pkg::Prod1W;
  localparam int unsigned DW = mewf_pkg::DiffW;
  localparam int unsigned P2 = mewf_pkg::Prod2W;
  localparam int unsigned WW = mewf_pkg::WeightW;

  // Configuration registers
  logic [mewf_pkg::GainW-1:0]  gain_q;
  logic [mewf_pkg::AlphaW-1:0] alpha_q;

  // Window storage and average
  logic signed [SW-1:0] win_q [WINDOW_SIZE];
  logic [IdxW-1:0]      wp_q;
  logic signed [WW-1:0] ema_q;

  // Sequencer
  mewf_pkg::state_e            state_q, state_d;
  logic [mewf_pkg::CountW-1:0] cnt_q;

  // Serial multiplier registers
  logic [P1-1:0]               mcand1_q, acc1_q;
  logic [mewf_pkg::GainW-1:0]  mplier1_q;
  logic [P2-1:0]               mcand2_q, acc2_q;
  logic [mewf_pkg::AlphaW-1:0] mplier2_q;
  logic signed [DW-1:0]        diff_q;

  // Output register
  logic                 out_valid_q;
  logic signed [WW-1:0] out_weight_q;
  logic                 out_upd_q;
  logic                 upd_q;

  logic in_fire, out_free;
  logic [IdxW-1:0] cur_idx;
  logic [RankW-1:0] rank;
  logic signed [SW-1:0] cur_val;
  logic signed [WW-1:0] w_val;
  logic signed [DW-1:0] delta;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == mewf_pkg::ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  assign out_o.valid           = out_valid_q;
  assign out_o.filtered_weight = out_weight_q;
  assign out_o.updated         = out_upd_q;

  // Rank of the slot under test: smaller values, and equal values in
  // lower slots, count below it.
  assign cur_idx = cnt_q[IdxW-1:0];
  assign cur_val = win_q[cur_idx];
  always_comb begin
    rank = '0;
    for (int j = 0; j < WINDOW_SIZE; j++) begin
      if ((win_q[j] < cur_val) || ((win_q[j] == cur_val) && (IdxW'(j) < cur_idx))) begin
        rank = rank + RankW'(1);
      end
    end
  end

  // Weight in Q32.16: product shifted right by 8 (floor); always fits 48 bits.
  assign w_val = acc1_q[P1-1:8];
  // Smoothing step: floor(alpha * diff / 2^16); stays between 0 and diff.
  assign delta = acc2_q[P2-1:mewf_pkg::AlphaW];

  always_comb begin
    state_d = state_q;
    case (state_q)
      mewf_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = (gain_q != '0) ? mewf_pkg::ST_RANK : mewf_pkg::ST_DONE;
        end
      end
      mewf_pkg::ST_RANK: begin
        if (rank == MedRank || cur_idx == LastIdx) begin
          state_d = mewf_pkg::ST_MUL1;
        end
      end
      mewf_pkg::ST_MUL1: begin
        if (cnt_q == mewf_pkg::CountW'(mewf_pkg::GainW - 1)) begin
          state_d = mewf_pkg::ST_SUB;
        end
      end
      mewf_pkg::ST_SUB:  state_d = mewf_pkg::ST_MUL2;
      mewf_pkg::ST_MUL2: begin
        if (cnt_q == mewf_pkg::CountW'(mewf_pkg::AlphaW - 1)) begin
          state_d = mewf_pkg::ST_DONE;
        end
      end
      mewf_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = mewf_pkg::ST_IDLE;
        end
      end
      default: state_d = mewf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mewf_pkg::ST_IDLE;
      gain_q      <= '0;
      alpha_q     <= mewf_pkg::AlphaReset;
      wp_q        <= '0;
      ema_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      upd_q       <= 1'b0;
      for (int k = 0; k < WINDOW_SIZE; k++) begin
        win_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_i.valid) begin
        case (cfg_i.index)
          mewf_pkg::REG_GAIN_RECIPROCAL:  gain_q  <= cfg_i.data;
          mewf_pkg::REG_SMOOTHING_WEIGHT: alpha_q <= cfg_i.data[mewf_pkg::AlphaW-1:0];
          default: ;
        endcase
      end

      // Drop a taken result unless the done state refills the register.
      if (out_valid_q && out_o.ready && state_q != mewf_pkg::ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        mewf_pkg::ST_IDLE: begin
          cnt_q <= '0;
          if (in_fire) begin
            upd_q <= (gain_q != '0);
            // Drop the sample while uncalibrated; else overwrite oldest slot.
            if (gain_q != '0) begin
              win_q[wp_q] <= in_i.raw_sample;
              wp_q        <= (wp_q == LastIdx) ? '0 : wp_q + IdxW'(1);
            end
          end
        end
        mewf_pkg::ST_RANK: begin
          if (rank == MedRank || cur_idx == LastIdx) begin
            cnt_q     <= '0;
            acc1_q    <= '0;
            mcand1_q  <= P1'(cur_val);
            mplier1_q <= gain_q;
          end else begin
            cnt_q <= cnt_q + mewf_pkg::CountW'(1);
          end
        end
        mewf_pkg::ST_MUL1: begin
          // Shift-add one gain bit per cycle.
          if (mplier1_q[0]) begin
            acc1_q <= acc1_q + mcand1_q;
          end
          mcand1_q  <= mcand1_q << 1;
          mplier1_q <= mplier1_q >> 1;
          cnt_q     <= cnt_q + mewf_pkg::CountW'(1);
        end
        mewf_pkg::ST_SUB: begin
          diff_q    <= DW'(w_val) - DW'(ema_q);
          cnt_q     <= '0;
          acc2_q    <= '0;
          mcand2_q  <= P2'(DW'(w_val) - DW'(ema_q));
          mplier2_q <= alpha_q;
        end
        mewf_pkg::ST_MUL2: begin
          if (mplier2_q[0]) begin
            acc2_q <= acc2_q + mcand2_q;
          end
          mcand2_q  <= mcand2_q << 1;
          mplier2_q <= mplier2_q >> 1;
          cnt_q     <= cnt_q + mewf_pkg::CountW'(1);
        end
        mewf_pkg::ST_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_upd_q    <= upd_q;
            if (upd_q) begin
              ema_q        <= ema_q + WW'(delta);
              out_weight_q <= ema_q + WW'(delta);
            end else begin
              out_weight_q <= ema_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Assertions
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= LastIdx) else $error("write slot out of range");

  a_uncal_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && gain_q == '0) |=> (state_q == mewf_pkg::ST_DONE && !upd_q))
    else $error("uncalibrated item entered datapath");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_weight_q)))
    else $error("pending result overwritten");

  a_diff_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mewf_pkg::ST_MUL2 && $past(state_q) == mewf_pkg::ST_MUL2)
    |-> $stable(diff_q))
    else $error("difference changed during smoothing multiply");

endmodule
